[src/ldf_pkg.sv]
// shared types and constants of the led dimmer with fade
package ldf_pkg;

  // percent values and their limits
  localparam int unsigned PCT_W   = 7;
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [PCT_W-1:0] PCT_OFF = 7'd0;
  localparam logic [PCT_W-1:0] PCT_ON_THRESH = 7'd49;

  // interface widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned FADE_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POLL_W  = 6;

  // duty = level * 255 / 100 as a multiply by a scaled reciprocal
  localparam int unsigned DUTY_MUL_W = 24;
  localparam logic [DUTY_MUL_W-1:0] DUTY_MUL = 24'd10695720;
  localparam int unsigned DUTY_SHIFT = 22;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FADE_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_INVERTED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SW_ACT_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SW_ENABLE    = 3'd4;

  // reset values of the configuration registers
  localparam logic [FADE_W-1:0] FADE_MS_RST = 16'd2000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_LEVEL  = 2'd1,
    CMD_SET_BRIGHT = 2'd2,
    CMD_SET_SWITCH = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_STEP,
    S_DONE
  } state_e;

endpackage

[src/ldf_div.sv]
// serial restoring divider, one quotient bit per cycle
module ldf_div #(
  parameter int unsigned DIVIDEND_W = 23,
  parameter int unsigned DIVISOR_W  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial     = {rem_q, quo_q[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, divisor_i};
    fits      = (trial >= {1'b0, divisor_i});
  end

  // control of the iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[src/led_dimmer_with_fade.sv]
// top level of the led dimmer with linear fade and polled local switch
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  in       | in_valid_i / in_ready_o  | command_i, value_i, switch_level_i
//  out      | out_valid_o / out_ready_i| pwm_duty_o, pin_high_o, level_percent_o,
//           |                          | target_percent_o, brightness_percent_o,
//           |                          | switch_on_o
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// after accept, a set transaction passes decode and result load on its way to the result
// register, a tick decode, fade step and result load; one that starts a fade also runs
// the serial step divider after decode. in_ready_o is high only in the idle state; a
// result waiting on out_ready_i holds the sequencer in its load state. reset gives level
// 0, target 0, brightness 100 and the listed register defaults; the config port is always
// ready.
module led_dimmer_with_fade #(
  parameter int unsigned POLL_TICKS = 50,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ldf_pkg::CMD_W-1:0]        command_i,
  input  logic [ldf_pkg::PCT_W-1:0]        value_i,
  input  logic                             switch_level_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ldf_pkg::DUTY_W-1:0]       pwm_duty_o,
  output logic                             pin_high_o,
  output logic [ldf_pkg::PCT_W-1:0]        level_percent_o,
  output logic [ldf_pkg::PCT_W-1:0]        target_percent_o,
  output logic [ldf_pkg::PCT_W-1:0]        brightness_percent_o,
  output logic                             switch_on_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ldf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ldf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import ldf_pkg::*;

  localparam int unsigned DIVW   = PCT_W + FRAC_BITS;
  localparam int unsigned STEP_W = DIVW + 1;
  localparam int unsigned FINE_W = FRAC_BITS + 9;

  // configuration registers
  logic [FADE_W-1:0] fade_ms_q;
  logic              pwm_mode_q;
  logic              out_inv_q;
  logic              sw_act_high_q;
  logic              sw_enable_q;

  // sequencer and item registers
  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [PCT_W-1:0]  val_q;
  logic              sw_q;

  // dimmer state
  logic [PCT_W-1:0]         level_q, level_d;
  logic [PCT_W-1:0]         target_q, target_d;
  logic [PCT_W-1:0]         bright_q, bright_d;
  logic signed [FINE_W-1:0] fine_q, fine_d;
  logic signed [STEP_W-1:0] step_q, step_d;
  logic [POLL_W-1:0]        poll_q, poll_d;
  logic                     seen_q, seen_d;
  logic                     dir_up_q, dir_up_d;

  // result register
  logic                     out_valid_q;
  logic [DUTY_W-1:0]        duty_q;
  logic                     pin_q;
  logic [PCT_W-1:0]         out_level_q;
  logic [PCT_W-1:0]         out_target_q;
  logic [PCT_W-1:0]         out_bright_q;
  logic                     out_sw_on_q;

  // divider hookup
  logic                     div_start;
  logic                     div_done;
  logic [DIVW-1:0]          div_dividend;
  logic [DIVW-1:0]          div_quotient;

  // decode helpers
  logic                     in_fire;
  logic                     out_free;
  logic [PCT_W-1:0]         val_sat;
  logic                     chg_req;
  logic [PCT_W-1:0]         chg_p;
  logic [POLL_W-1:0]        poll_nx;
  logic                     pressed;
  logic [PCT_W-1:0]         diff;
  logic [DIVW-1:0]          mag;

  // fade step helpers
  logic signed [FINE_W-1:0] goal;
  logic signed [FINE_W-1:0] fine_sum;
  logic signed [FINE_W-1:0] fine_new;
  logic                     step_pos;
  logic [7:0]               lvl_int;

  // duty product
  logic [PCT_W+DUTY_MUL_W-1:0] duty_prod;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign val_sat     = (value_i > PCT_MAX) ? PCT_MAX : value_i;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_ms_q     <= FADE_MS_RST;
      pwm_mode_q    <= 1'b1;
      out_inv_q     <= 1'b0;
      sw_act_high_q <= 1'b0;
      sw_enable_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FADE_MS:      fade_ms_q     <= cfg_data_i[FADE_W-1:0];
        REG_PWM_MODE:     pwm_mode_q    <= cfg_data_i[0];
        REG_OUT_INVERTED: out_inv_q     <= cfg_data_i[0];
        REG_SW_ACT_HIGH:  sw_act_high_q <= cfg_data_i[0];
        REG_SW_ENABLE:    sw_enable_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= val_sat;
      sw_q  <= switch_level_i;
    end
  end

  // requested target change for the current command, switch polling on ticks
  always_comb begin
    chg_req = 1'b0;
    chg_p   = PCT_OFF;
    poll_nx = poll_q + 1'b1;
    pressed = !sw_q;
    poll_d  = poll_q;
    seen_d  = seen_q;
    bright_d = bright_q;
    unique case (cmd_q)
      CMD_TICK: begin
        if (poll_nx >= POLL_W'(POLL_TICKS)) begin
          poll_d = '0;
          if (sw_enable_q && (pressed != seen_q)) begin
            seen_d  = pressed;
            chg_req = 1'b1;
            chg_p   = (pressed == sw_act_high_q) ? PCT_OFF : PCT_MAX;
          end
        end else begin
          poll_d = poll_nx;
        end
      end
      CMD_SET_LEVEL: begin
        chg_req = 1'b1;
        chg_p   = val_q;
      end
      CMD_SET_BRIGHT: begin
        bright_d = val_q;
        chg_req  = (level_q != PCT_OFF) && (level_q != val_q);
        chg_p    = val_q;
      end
      CMD_SET_SWITCH: begin
        if (val_q != PCT_OFF) begin
          chg_req = (target_q == PCT_OFF);
          chg_p   = bright_q;
        end else begin
          chg_req = 1'b1;
          chg_p   = PCT_OFF;
        end
      end
      default: ;
    endcase
  end

  // step dividend and the fixed-up step magnitude
  assign diff         = (chg_p > level_q) ? (chg_p - level_q) : (level_q - chg_p);
  assign div_dividend = {diff, {FRAC_BITS{1'b0}}};
  assign mag          = (div_quotient == '0) ? DIVW'(1) : div_quotient;

  // one fade step: add, clamp at the goal, derive the integer level
  always_comb begin
    goal     = $signed({2'b00, target_q, {FRAC_BITS{1'b0}}});
    fine_sum = fine_q + $signed({step_q[STEP_W-1], step_q});
    step_pos = !step_q[STEP_W-1] && (step_q != '0);
    if (step_pos) begin
      fine_new = (fine_sum >= goal) ? goal : fine_sum;
    end else begin
      fine_new = (fine_sum <= goal) ? goal : fine_sum;
    end
    lvl_int = fine_new[FRAC_BITS +: 8];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    target_d  = target_q;
    fine_d    = fine_q;
    step_d    = step_q;
    dir_up_d  = dir_up_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (chg_req && (chg_p != target_q)) begin
          target_d = chg_p;
          if ((fade_ms_q == '0) || !pwm_mode_q) begin
            level_d = chg_p;
          end else if (level_q != chg_p) begin
            fine_d    = $signed({2'b00, level_q, {FRAC_BITS{1'b0}}});
            dir_up_d  = (chg_p > level_q);
            div_start = 1'b1;
          end
        end
        if (div_start) begin
          state_d = S_DIV;
        end else if (cmd_q == CMD_TICK) begin
          state_d = S_STEP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          step_d  = dir_up_q ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
          state_d = (cmd_q == CMD_TICK) ? S_STEP : S_DONE;
        end
      end
      S_STEP: begin
        if (level_q != target_q) begin
          fine_d = fine_new;
          if (fine_new <= 0) begin
            level_d = PCT_OFF;
          end else if (lvl_int > {1'b0, PCT_MAX}) begin
            level_d = PCT_MAX;
          end else begin
            level_d = lvl_int[PCT_W-1:0];
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      level_q  <= PCT_OFF;
      target_q <= PCT_OFF;
      bright_q <= PCT_MAX;
      fine_q   <= '0;
      step_q   <= '0;
      poll_q   <= '0;
      seen_q   <= 1'b0;
      dir_up_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      level_q  <= level_d;
      target_q <= target_d;
      fine_q   <= fine_d;
      step_q   <= step_d;
      dir_up_q <= dir_up_d;
      if (state_q == S_DECODE) begin
        poll_q   <= poll_d;
        seen_q   <= seen_d;
        bright_q <= bright_d;
      end
    end
  end

  // step divider
  ldf_div #(
    .DIVIDEND_W (DIVW),
    .DIVISOR_W  (FADE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (fade_ms_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // result register
  assign duty_prod = level_q * DUTY_MUL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      duty_q       <= duty_prod[DUTY_SHIFT +: DUTY_W];
      pin_q        <= (level_q > PCT_ON_THRESH) ^ out_inv_q;
      out_level_q  <= level_q;
      out_target_q <= target_q;
      out_bright_q <= bright_q;
      out_sw_on_q  <= (target_q != PCT_OFF);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pwm_duty_o           = duty_q;
  assign pin_high_o           = pin_q;
  assign level_percent_o      = out_level_q;
  assign target_percent_o     = out_target_q;
  assign brightness_percent_o = out_bright_q;
  assign switch_on_o          = out_sw_on_q;

endmodule
